[rtl/substring_finder_unit_macros.svh]
// Assertion helpers shared by substring_finder_unit and sfu_window_match
`ifndef SUBSTRING_FINDER_UNIT_MACROS_SVH
`define SUBSTRING_FINDER_UNIT_MACROS_SVH

// Check a condition at every clock edge outside of reset
`define SFU_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("substring finder check failed");

// Check that a trigger is followed by a condition in the next cycle
`define SFU_ASSERT_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("substring finder sequence check failed");

`endif

[rtl/sfu_pkg.sv]
package sfu_pkg;

  // Widths fixed by the register map and the stream fields
  localparam int unsigned PatternRegs     = 4;
  localparam int unsigned PatternRegBytes = 8 * PatternRegs;
  localparam int unsigned CfgDataBits     = 64;
  localparam int unsigned CfgIndexBits    = 3;
  localparam int unsigned LenBits         = 6;
  localparam int unsigned StartBits       = 32;
  localparam int unsigned ModeBits        = 3;
  localparam int unsigned IndexOutBits    = 32;
  localparam int unsigned CalcBits        = 64;

  // Parameter defaults
  localparam int unsigned PatternMaxDef   = 32;
  localparam int unsigned PositionBitsDef = 32;

  // Mode bits
  localparam int unsigned ModeLastBit  = 0;
  localparam int unsigned ModeCaseBit  = 1;
  localparam int unsigned ModeSlashBit = 2;

  // Character codes
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharUpperA    = 8'h41;
  localparam logic [7:0] CharUpperZ    = 8'h5A;
  localparam logic [7:0] CharLowerA    = 8'h61;
  localparam logic [7:0] CharLowerZ    = 8'h7A;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgPat0   = 3'd0,
    CfgPat1   = 3'd1,
    CfgPat2   = 3'd2,
    CfgPat3   = 3'd3,
    CfgPatLen = 3'd4,
    CfgStart  = 3'd5,
    CfgMode   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PatternRegBytes-1:0][7:0] pattern;
    logic [LenBits-1:0]              pattern_len;
    logic [StartBits-1:0]            start_index;
    logic [ModeBits-1:0]             mode;
  } sfu_cfg_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharUpperA && c <= CharUpperZ) r = c + (CharLowerA - CharUpperA);
    return r;
  endfunction

  function automatic logic [7:0] fold_slash(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CharSlash || c == CharBackslash) r = CharSlash;
    return r;
  endfunction

  // A pair agrees if any enabled comparison accepts it
  function automatic logic bytes_agree(input logic [7:0] x, input logic [7:0] y,
                                       input logic [ModeBits-1:0] mode);
    logic ok;
    ok = (x == y);
    if (mode[ModeCaseBit])  ok = ok | (fold_case(x) == fold_case(y));
    if (mode[ModeSlashBit]) ok = ok | (fold_slash(x) == fold_slash(y));
    return ok;
  endfunction

endpackage

[rtl/substring_finder_unit.sv]
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] text_byte, tlast final_byte
// m_axis    out        tdata[31:0] match_index, tuser[0] found, tuser[1] index_saturated
// cfg       in         cfg_index_i register index, cfg_data_i value
//
// One text byte per cycle unless s_axis stalls; a byte passes an input register,
// then the window compare and position tracking update the result register.
// A result appears only for the final byte of a text; the search state clears there.
// s_axis stalls only while a byte sits in the input register and a result is held.
// Reset is asynchronous, active low; all patterns and lengths read as zero after it.
module substring_finder_unit import sfu_pkg::*; #(
  parameter int unsigned PATTERN_MAX   = PatternMaxDef,
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] text_byte
  input  logic                    s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [IndexOutBits-1:0] m_axis_tdata,   // [31:0] match_index
  output logic [1:0]              m_axis_tuser,   // [0] found, [1] index_saturated
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  sfu_cfg_t cfg;

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             stall, proc;

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] hit_pos_q, hit_pos_d;
  logic                     hit_seen_q, hit_seen_d;
  logic                     ovf_q, ovf_d;

  logic                     out_valid_q;
  logic [IndexOutBits-1:0]  out_index_q;
  logic                     out_found_q, out_sat_q;

  logic [LenBits-1:0]       len;
  logic                     window_hit;
  logic [CalcBits-1:0]      p_next_wide, start_wide;
  logic [POSITION_BITS-1:0] s_pos, idx_pos;
  logic                     cand, take;
  logic [CalcBits-1:0]      idx_wide;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  sfu_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Hold off the input only when the result register cannot drain
  assign stall         = out_valid_q && !m_axis_tready;
  assign proc          = in_valid_q && !stall;
  assign s_axis_tready = !in_valid_q || !stall;

  // Clamp the pattern length to the window depth
  assign len = (cfg.pattern_len > LenBits'(PATTERN_MAX)) ?
               LenBits'(PATTERN_MAX) : cfg.pattern_len;

  sfu_window_match #(
    .PatternMax (PATTERN_MAX)
  ) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (proc),
    .byte_i    (in_byte_q),
    .len_i     (len),
    .pattern_i (cfg.pattern),
    .mode_i    (cfg.mode),
    .hit_o     (window_hit)
  );

  // Match start and acceptance for the byte in the input register
  always_comb begin
    p_next_wide = CalcBits'(pos_q) + CalcBits'(1);
    start_wide  = CalcBits'(cfg.start_index);
    cand        = !ovf_q && (p_next_wide >= CalcBits'(len));
    if (len == '0) begin
      s_pos = pos_q;
    end else begin
      s_pos = POSITION_BITS'(p_next_wide - CalcBits'(len));
    end
    take = cand && (CalcBits'(s_pos) >= start_wide) &&
           (!hit_seen_q || cfg.mode[ModeLastBit]) && window_hit;
  end

  // Next position tracking state
  always_comb begin
    hit_seen_d = hit_seen_q | take;
    hit_pos_d  = take ? s_pos : hit_pos_q;
    ovf_d      = ovf_q | (pos_q == PosMax);
    pos_d      = (pos_q == PosMax) ? pos_q : pos_q + POSITION_BITS'(1);
    idx_pos    = hit_seen_d ? hit_pos_d : pos_d;
    idx_wide   = CalcBits'(idx_pos);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Search state; clear after the final byte of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hit_pos_q  <= '0;
      hit_seen_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (proc) begin
      if (in_last_q) begin
        pos_q      <= '0;
        hit_pos_q  <= '0;
        hit_seen_q <= 1'b0;
        ovf_q      <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        hit_pos_q  <= hit_pos_d;
        hit_seen_q <= hit_seen_d;
        ovf_q      <= ovf_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      out_index_q <= idx_wide[IndexOutBits-1:0];
      out_found_q <= hit_seen_d;
      out_sat_q   <= ovf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_index_q;
  assign m_axis_tuser  = {out_sat_q, out_found_q};

  `include "substring_finder_unit_macros.svh"

  `SFU_ASSERT_NEXT(a_clear_after_text, proc && in_last_q, pos_q == '0 && !hit_seen_q && !ovf_q)
  `SFU_ASSERT_ALWAYS(a_hit_not_ahead, hit_pos_q <= pos_q)
  `SFU_ASSERT_ALWAYS(a_ovf_at_max, !ovf_q || pos_q == PosMax)
  `SFU_ASSERT_ALWAYS(a_stall_cause, s_axis_tready || (in_valid_q && out_valid_q && !m_axis_tready))

endmodule

[rtl/sfu_cfg_regs.sv]
module sfu_cfg_regs import sfu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [CfgIndexBits-1:0] wr_index_i,
  input  logic [CfgDataBits-1:0]  wr_data_i,
  output sfu_cfg_t                cfg_o
);

  sfu_cfg_t cfg_q, cfg_d;

  // Decode the register index and update one field
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CfgPat0:   cfg_d.pattern[7:0]   = wr_data_i;
        CfgPat1:   cfg_d.pattern[15:8]  = wr_data_i;
        CfgPat2:   cfg_d.pattern[23:16] = wr_data_i;
        CfgPat3:   cfg_d.pattern[31:24] = wr_data_i;
        CfgPatLen: cfg_d.pattern_len    = wr_data_i[LenBits-1:0];
        CfgStart:  cfg_d.start_index    = wr_data_i[StartBits-1:0];
        CfgMode:   cfg_d.mode           = wr_data_i[ModeBits-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/sfu_window_match.sv]
module sfu_window_match import sfu_pkg::*; #(
  parameter int unsigned PatternMax = PatternMaxDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [7:0]                      byte_i,
  input  logic [LenBits-1:0]              len_i,
  input  logic [PatternRegBytes-1:0][7:0] pattern_i,
  input  logic [ModeBits-1:0]             mode_i,
  output logic                            hit_o
);

  localparam int unsigned PatIdxBits = $clog2(PatternRegBytes);

  logic [7:0] win_q [PatternMax];
  logic [7:0] win_d [PatternMax];

  // Window after the incoming byte is shifted in, newest in entry 0
  always_comb begin
    win_d[0] = byte_i;
    for (int j = 1; j < PatternMax; j++) begin
      win_d[j] = win_q[j-1];
    end
  end

  // Compare each window entry in use with its pattern byte
  always_comb begin
    logic [PatIdxBits-1:0] idx;
    logic                  ok;
    ok = 1'b1;
    for (int j = 0; j < PatternMax; j++) begin
      idx = PatIdxBits'(len_i - LenBits'(j) - LenBits'(1));
      if (LenBits'(j) < len_i) begin
        if (!bytes_agree(win_d[j], pattern_i[idx], mode_i)) ok = 1'b0;
      end
    end
    hit_o = ok;
  end

  // Advance the window on each processed byte
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int j = 0; j < PatternMax; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end

  `include "substring_finder_unit_macros.svh"

  `SFU_ASSERT_NEXT(a_win_newest, step_i, win_q[0] == $past(byte_i))

endmodule
